// ----- rtl/pbr_pkg.sv -----
// Package for the point-to-box range test.
// Holds the word width, lane count, pipeline depth and the lane result type.
// No dependencies.
package pbr_pkg;

    localparam int WORD_W  = 32;
    localparam int LANE_N  = 3;
    // Edges from an accepted transaction to its result strobe.
    localparam int LATENCY = 7;

    // What one axis lane hands to the merging stage.
    typedef struct packed {
        logic [WORD_W-1:0] term;
        logic              outside;
    } lane_out_t;

endpackage

// ----- rtl/point_box_range_test.sv -----
// Top level of the point-to-box range test: three axis lanes and a merging stage.
// Depends on pbr_pkg, pbr_lane and pbr_merge.
//
//   channel   signals                          direction  transaction
//   command   start, busy, centre_*, extent_*, in         start high, busy low
//             point_*, reach
//   result    done, in_range                   out        done high for one cycle
//
// One transaction may be accepted in every cycle; busy is never raised.
// Each result is registered through the lane pipeline (corners, overshoot,
// magnitude, square, term) and then through the two merge stages.
// Reset clears only the valid pipeline; data registers carry no reset.
// The receiver cannot stall, so results are never held back.
module point_box_range_test
    import pbr_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] centre_x,
    input  logic signed [WORD_W-1:0] centre_y,
    input  logic signed [WORD_W-1:0] centre_z,
    input  logic signed [WORD_W-1:0] extent_a,
    input  logic signed [WORD_W-1:0] extent_b,
    input  logic signed [WORD_W-1:0] extent_c,
    input  logic signed [WORD_W-1:0] point_x,
    input  logic signed [WORD_W-1:0] point_y,
    input  logic signed [WORD_W-1:0] point_z,
    input  logic signed [WORD_W-1:0] reach,
    output logic                     done,
    output logic                     in_range
);

    lane_out_t            lanes [LANE_N];
    logic [LATENCY-1:0]   vld_reg, vld_next;

    assign busy = 1'b0;

    // Lane x: low corner uses extent_a, high corner extent_b.
    pbr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x
    (
        .clk      (clk),
        .centre   (centre_x),
        .ext_low  (extent_a),
        .ext_high (extent_b),
        .point    (point_x),
        .result   (lanes[0])
    );

    // Lane y: low corner uses extent_a, high corner extent_c.
    pbr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y
    (
        .clk      (clk),
        .centre   (centre_y),
        .ext_low  (extent_a),
        .ext_high (extent_c),
        .point    (point_y),
        .result   (lanes[1])
    );

    // Lane z: low corner uses extent_b, high corner extent_c.
    pbr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z
    (
        .clk      (clk),
        .centre   (centre_z),
        .ext_low  (extent_b),
        .ext_high (extent_c),
        .point    (point_z),
        .result   (lanes[2])
    );

    pbr_merge #(.FRAC_BITS(FRAC_BITS)) u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .reach    (reach),
        .lanes    (lanes),
        .in_range (in_range)
    );

    // Valid pipeline that tracks each accepted transaction to its strobe.
    assign vld_next = {vld_reg[LATENCY-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done = vld_reg[LATENCY-1];

endmodule

// ----- rtl/pbr_lane.sv -----
// One axis lane: box corners, overshoot, rounded square term.
// Depends on pbr_pkg. Five register stages, one new transaction per cycle.
module pbr_lane
    import pbr_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                     clk,
    input  logic signed [WORD_W-1:0] centre,
    input  logic signed [WORD_W-1:0] ext_low,
    input  logic signed [WORD_W-1:0] ext_high,
    input  logic signed [WORD_W-1:0] point,
    output lane_out_t                result
);

    localparam int          SQ_W = 2 * WORD_W;
    localparam logic [SQ_W-1:0] RND =
        (FRAC_BITS > 0) ? (SQ_W'(1) << (FRAC_BITS - 1)) : '0;

    logic signed [WORD_W-1:0] lo_reg, hi_reg, pt_reg;
    logic signed [WORD_W-1:0] diff_reg, diff_next;
    logic [WORD_W-1:0]        mag_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_rnd;
    logic [WORD_W-1:0]        term_reg;
    logic                     out2_reg, out3_reg, out4_reg, out5_reg, out_next;
    logic signed [WORD_W-1:0] d_low, d_high;

    // Overshoot below the low corner or above the high corner, wrapping at 32 bits.
    always_comb
    begin
        d_low  = lo_reg - pt_reg;
        d_high = pt_reg - hi_reg;
        if (lo_reg > pt_reg)
        begin
            diff_next = d_low;
            out_next  = 1'b1;
        end
        else if (hi_reg < pt_reg)
        begin
            diff_next = d_high;
            out_next  = 1'b1;
        end
        else
        begin
            diff_next = '0;
            out_next  = 1'b0;
        end
    end

    // Rounding before the fractional shift.
    assign sq_rnd = sq_reg + RND;

    // Pipeline: corners, overshoot, magnitude, square, term.
    always_ff @(posedge clk)
    begin
        lo_reg   <= centre - ext_low;
        hi_reg   <= centre + ext_high;
        pt_reg   <= point;
        diff_reg <= diff_next;
        out2_reg <= out_next;
        mag_reg  <= diff_reg[WORD_W-1] ? WORD_W'(-diff_reg) : WORD_W'(diff_reg);
        out3_reg <= out2_reg;
        sq_reg   <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        out4_reg <= out3_reg;
        term_reg <= WORD_W'(sq_rnd >> FRAC_BITS);
        out5_reg <= out4_reg;
    end

    assign result.term    = term_reg;
    assign result.outside = out5_reg;

endmodule

// ----- rtl/pbr_merge.sv -----
// Merging stage: sums the lane terms and compares against the squared reach.
// Depends on pbr_pkg. The reach path is pipelined to meet the lane results.
module pbr_merge
    import pbr_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [WORD_W-1:0] reach,
    input  lane_out_t                lanes [LANE_N],
    output logic                     in_range
);

    localparam int SQ_W = 2 * WORD_W;

    logic signed [WORD_W-1:0] reach1_reg, reach2_reg;
    logic [WORD_W-1:0]        rp1_reg;
    logic                     nn3_reg, nn4_reg, nn5_reg, nn6_reg;
    logic [SQ_W-1:0]          rsq4_reg, rsq5_reg, rsq6_reg;
    logic [WORD_W-1:0]        sum_reg;
    logic                     outside_reg;
    logic                     in_range_reg, in_range_next;
    logic [SQ_W-1:0]          radicand;

    // Reach side: floor(sqrt(n)) <= r exactly when (r + 1)^2 > n for r >= 0.
    always_ff @(posedge clk)
    begin
        reach1_reg <= reach;
        reach2_reg <= reach1_reg;
        rp1_reg    <= WORD_W'(reach2_reg) + WORD_W'(1);
        nn3_reg    <= !reach2_reg[WORD_W-1];
        rsq4_reg   <= SQ_W'(rp1_reg) * SQ_W'(rp1_reg);
        nn4_reg    <= nn3_reg;
        rsq5_reg   <= rsq4_reg;
        nn5_reg    <= nn4_reg;
        rsq6_reg   <= rsq5_reg;
        nn6_reg    <= nn5_reg;
    end

    // Sum of terms, wrapping at 32 bits, and whether any axis lies outside.
    always_ff @(posedge clk)
    begin
        sum_reg     <= lanes[0].term + lanes[1].term + lanes[2].term;
        outside_reg <= lanes[0].outside | lanes[1].outside | lanes[2].outside;
    end

    assign radicand = SQ_W'(sum_reg) << FRAC_BITS;

    // Decision: inside, negative reach, zero root, or the squared compare.
    always_comb
    begin
        if (!outside_reg)
            in_range_next = 1'b1;
        else if (!nn6_reg)
            in_range_next = 1'b0;
        else if (sum_reg[WORD_W-1] || (sum_reg == '0))
            in_range_next = 1'b1;
        else
            in_range_next = (rsq6_reg > radicand);
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
    end

    assign in_range = in_range_reg;

    // A point inside the box is always in range.
    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        !outside_reg |=> in_range_reg)
        else $error("inside point reported out of range");

    // A negative reach never covers a point outside the box.
    a_neg_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (outside_reg && !nn6_reg) |=> !in_range_reg)
        else $error("negative reach reported in range");

    // A non-positive sum gives a zero root, which any non-negative reach covers.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (outside_reg && nn6_reg && (sum_reg[WORD_W-1] || (sum_reg == '0)))
        |=> in_range_reg)
        else $error("zero root with non-negative reach reported out of range");

endmodule
